[hdl/gha_pkg.sv]
// gha_pkg: shared constants, codes and control types of the handle allocator
// used by gha_ctrl, gha_datapath and generational_handle_allocator_top
package gha_pkg;

    localparam int CHUNK_SLOTS = 1024;
    localparam int MAX_CHUNKS  = 8;
    localparam int GEN_BITS    = 16;

    localparam int SLOT_W   = $clog2(CHUNK_SLOTS);
    localparam int CHUNK_W  = $clog2(MAX_CHUNKS);
    localparam int BIT_W    = 5;
    localparam int WORD_BITS = 1 << BIT_W;
    localparam int WORD_W   = SLOT_W - BIT_W;
    localparam int ROW_W    = CHUNK_W + WORD_W;
    localparam int ROWS     = MAX_CHUNKS * CHUNK_SLOTS / WORD_BITS;
    localparam int ADDR_W   = CHUNK_W + SLOT_W;
    localparam int ENTRIES  = MAX_CHUNKS * CHUNK_SLOTS;
    localparam int DEPTH_W  = SLOT_W + 1;
    localparam int NCH_W    = CHUNK_W + 1;
    localparam int CNT_W    = 14;
    localparam int LIM_W    = 4;
    localparam int POP_W    = BIT_W + 1;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 64;
    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(8);

    typedef enum logic [3:0] {
        REQ_CREATE      = 4'd0,
        REQ_RESTORE     = 4'd1,
        REQ_DESTROY     = 4'd2,
        REQ_LOCK        = 4'd3,
        REQ_UNLOCK      = 4'd4,
        REQ_IS_ALIVE    = 4'd5,
        REQ_IS_LOCKED   = 4'd6,
        REQ_GROW        = 4'd7,
        REQ_DESTROY_ALL = 4'd8,
        REQ_LOCK_ALL    = 4'd9,
        REQ_UNLOCK_ALL  = 4'd10,
        REQ_LIVE_COUNT  = 4'd11
    } req_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_NO_FREE = 3'd1,
        STAT_DEAD    = 3'd2,
        STAT_LOCKED  = 3'd3,
        STAT_LIMIT   = 3'd4
    } stat_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_FETCH,
        S_MODIFY,
        S_GROW,
        S_SW_ADDR,
        S_SW_DATA,
        S_SW_PUSH,
        S_SW_END,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic pop_rd;
        logic slot_rd_req;
        logic slot_rd_top;
        logic modify;
        logic finish_direct;
        logic grow_wr;
        logic sw_rd;
        logic sw_eval;
        logic sw_push;
        logic sw_next;
        logic sw_end;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic take_ok;
        logic grow_ok;
        logic have_chunks;
        logic clr_last;
        logic grow_last;
        logic last_row;
        logic sel_nz;
        logic rest_nz;
        logic out_free;
    } sts_t;

    function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

[hdl/gha_ram.sv]
// gha_ram: generic single-write, single-read ram with registered read data
// no dependencies
module gha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/gha_datapath.sv]
// gha_datapath: request and result registers, chunk stacks, counters and the
// generation, valid, lock and free-slot memories; uses gha_pkg and gha_ram
module gha_datapath
    import gha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              cfg_valid,
    input  logic [LIM_W-1:0]  cfg_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    req_t                 req_reg, req_next;
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [GEN_BITS-1:0]  gin_reg, gin_next;
    logic [LIM_W-1:0]     limit_reg, limit_next;

    logic [DEPTH_W-1:0]   fd_reg [MAX_CHUNKS];
    logic [DEPTH_W-1:0]   fd_next [MAX_CHUNKS];
    logic [CHUNK_W-1:0]   ustack_reg [MAX_CHUNKS];
    logic [CHUNK_W-1:0]   ustack_next [MAX_CHUNKS];
    logic [MAX_CHUNKS-1:0] usable_reg, usable_next;
    logic [NCH_W-1:0]     udepth_reg, udepth_next;
    logic [NCH_W-1:0]     nchunks_reg, nchunks_next;
    logic [CNT_W-1:0]     live_reg, live_next;

    stat_t                res_status_reg, res_status_next;
    logic [CHUNK_W-1:0]   res_chunk_reg, res_chunk_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [GEN_BITS-1:0]  res_gen_reg, res_gen_next;
    logic                 res_flag_reg, res_flag_next;
    logic [CNT_W-1:0]     res_count_reg, res_count_next;

    logic [ROW_W-1:0]     row_reg, row_next;
    logic [WORD_BITS-1:0] pend_reg, pend_next;
    logic [ADDR_W-1:0]    ctr_reg, ctr_next;

    logic                 mvalid_reg, mvalid_next;
    logic [OUT_W-1:0]     mdata_reg, mdata_next;

    logic                 gwe, vwe, lwe, fwe;
    logic [ADDR_W-1:0]    gwaddr, graddr, fwaddr, fraddr;
    logic [GEN_BITS-1:0]  gwdata, grdata;
    logic [ROW_W-1:0]     vwaddr, lwaddr, vlraddr;
    logic [WORD_BITS-1:0] vwdata, lwdata, vrdata, lrdata;
    logic [SLOT_W-1:0]    fwdata, frdata;

    logic [NCH_W-1:0]     udm1;
    logic [CHUNK_W-1:0]   top_chunk;
    logic [DEPTH_W-1:0]   top_fdm1;
    logic [NCH_W-1:0]     lastc;
    logic                 in_range;
    logic [WORD_BITS-1:0] mask;
    logic                 live_hit;
    logic [WORD_BITS-1:0] sel;
    logic [BIT_W-1:0]     low_idx;
    logic [DEPTH_W-1:0]   dec_depth;
    logic                 push_en, mk_en;
    logic [CHUNK_W-1:0]   push_chunk, mk_chunk;
    logic [SLOT_W-1:0]    push_slot;

    assign udm1      = udepth_reg - NCH_W'(1);
    assign top_chunk = ustack_reg[udm1[CHUNK_W-1:0]];
    assign top_fdm1  = fd_reg[top_chunk] - DEPTH_W'(1);
    assign lastc     = nchunks_reg - NCH_W'(1);
    assign in_range  = {1'b0, chunk_reg} < nchunks_reg;
    assign mask      = WORD_BITS'(1) << slot_reg[BIT_W-1:0];
    assign live_hit  = in_range && vrdata[slot_reg[BIT_W-1:0]] && (grdata == gin_reg);
    assign sel       = (req_reg == REQ_UNLOCK_ALL) ? lrdata : (vrdata & ~lrdata);

    always_comb
    begin
        low_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (pend_reg[b])
            begin
                low_idx = BIT_W'(b);
            end
        end
    end

    // read addresses
    assign fraddr = {top_chunk, top_fdm1[SLOT_W-1:0]};
    assign graddr = cmd.slot_rd_top ? {chunk_reg, frdata} : {chunk_reg, slot_reg};
    always_comb
    begin
        if (cmd.sw_rd)
        begin
            vlraddr = row_reg;
        end
        else if (cmd.slot_rd_top)
        begin
            vlraddr = {chunk_reg, frdata[SLOT_W-1:BIT_W]};
        end
        else
        begin
            vlraddr = {chunk_reg, slot_reg[SLOT_W-1:BIT_W]};
        end
    end

    assign sts.req         = req_reg;
    assign sts.take_ok     = (udepth_reg != '0) && (fd_reg[top_chunk] != '0);
    assign sts.grow_ok     = (nchunks_reg < NCH_W'(limit_reg))
                             && (nchunks_reg < NCH_W'(MAX_CHUNKS));
    assign sts.have_chunks = nchunks_reg != '0;
    assign sts.clr_last    = &ctr_reg;
    assign sts.grow_last   = &ctr_reg[SLOT_W-1:0];
    assign sts.last_row    = row_reg == {lastc[CHUNK_W-1:0], {WORD_W{1'b1}}};
    assign sts.sel_nz      = sel != '0;
    assign sts.rest_nz     = (pend_reg & (pend_reg - WORD_BITS'(1))) != '0;
    assign sts.out_free    = !mvalid_reg || m_tready;

    always_comb
    begin
        req_next        = req_reg;
        chunk_next      = chunk_reg;
        slot_next       = slot_reg;
        gin_next        = gin_reg;
        limit_next      = cfg_valid ? cfg_data : limit_reg;
        fd_next         = fd_reg;
        ustack_next     = ustack_reg;
        usable_next     = usable_reg;
        udepth_next     = udepth_reg;
        nchunks_next    = nchunks_reg;
        live_next       = live_reg;
        res_status_next = res_status_reg;
        res_chunk_next  = res_chunk_reg;
        res_slot_next   = res_slot_reg;
        res_gen_next    = res_gen_reg;
        res_flag_next   = res_flag_reg;
        res_count_next  = res_count_reg;
        row_next        = row_reg;
        pend_next       = pend_reg;
        ctr_next        = ctr_reg;
        mvalid_next     = mvalid_reg;
        mdata_next      = mdata_reg;
        gwe = 1'b0; gwaddr = {chunk_reg, slot_reg}; gwdata = '0;
        vwe = 1'b0; vwaddr = {chunk_reg, slot_reg[SLOT_W-1:BIT_W]}; vwdata = '0;
        lwe = 1'b0; lwaddr = {chunk_reg, slot_reg[SLOT_W-1:BIT_W]}; lwdata = '0;
        fwe = 1'b0; fwaddr = '0; fwdata = '0;
        push_en = 1'b0; push_chunk = chunk_reg; push_slot = slot_reg;
        mk_en = 1'b0; mk_chunk = chunk_reg;
        dec_depth = fd_reg[chunk_reg] - DEPTH_W'(1);

        if (cmd.capture)
        begin
            req_next        = req_t'(s_tdata[3:0]);
            chunk_next      = s_tdata[6:4];
            slot_next       = s_tdata[16:7];
            gin_next        = s_tdata[32:17];
            res_status_next = STAT_OK;
            res_chunk_next  = '0;
            res_slot_next   = '0;
            res_gen_next    = '0;
            res_flag_next   = 1'b0;
            res_count_next  = '0;
            row_next        = '0;
            ctr_next        = '0;
        end

        // clearing pass after reset
        if (cmd.clr_wr)
        begin
            gwe = 1'b1; gwaddr = ctr_reg; gwdata = '0;
            vwe = ctr_reg < ADDR_W'(ROWS); vwaddr = ctr_reg[ROW_W-1:0];
            lwe = vwe; lwaddr = ctr_reg[ROW_W-1:0];
            ctr_next = ctr_reg + ADDR_W'(1);
        end

        if (cmd.pop_rd)
        begin
            chunk_next = top_chunk;
        end
        if (cmd.slot_rd_top)
        begin
            slot_next = frdata;
        end

        if (cmd.finish_direct)
        begin
            case (req_reg) inside
                REQ_CREATE, REQ_RESTORE: res_status_next = STAT_NO_FREE;
                REQ_GROW:                res_status_next = STAT_LIMIT;
                REQ_LIVE_COUNT:
                begin
                    if (in_range)
                    begin
                        res_count_next = CNT_W'(CHUNK_SLOTS) - CNT_W'(fd_reg[chunk_reg]);
                    end
                    else
                    begin
                        res_status_next = STAT_DEAD;
                    end
                end
                default:                 res_status_next = STAT_OK;
            endcase
        end

        if (cmd.modify)
        begin
            case (req_reg) inside
                REQ_CREATE, REQ_RESTORE:
                begin
                    fd_next[chunk_reg] = dec_depth;
                    if (dec_depth == '0)
                    begin
                        usable_next[chunk_reg] = 1'b0;
                        udepth_next = udepth_reg - NCH_W'(1);
                    end
                    vwe = 1'b1; vwdata = vrdata | mask;
                    live_next = live_reg + CNT_W'(1);
                    res_chunk_next = chunk_reg;
                    res_slot_next  = slot_reg;
                    if (req_reg == REQ_CREATE)
                    begin
                        gwe = 1'b1; gwdata = grdata + GEN_BITS'(1);
                        res_gen_next = grdata + GEN_BITS'(1);
                    end
                    else
                    begin
                        res_gen_next = grdata;
                    end
                end
                REQ_DESTROY:
                begin
                    if (!live_hit)
                    begin
                        res_status_next = STAT_DEAD;
                    end
                    else if ((lrdata & mask) != '0)
                    begin
                        res_status_next = STAT_LOCKED;
                    end
                    else
                    begin
                        vwe = 1'b1; vwdata = vrdata & ~mask;
                        lwe = 1'b1; lwdata = lrdata & ~mask;
                        push_en = 1'b1;
                        live_next = live_reg - CNT_W'(1);
                    end
                end
                REQ_LOCK, REQ_UNLOCK:
                begin
                    if (!live_hit)
                    begin
                        res_status_next = STAT_DEAD;
                    end
                    else
                    begin
                        lwe = 1'b1;
                        lwdata = (req_reg == REQ_LOCK) ? (lrdata | mask) : (lrdata & ~mask);
                    end
                end
                REQ_IS_ALIVE:  res_flag_next = live_hit;
                REQ_IS_LOCKED: res_flag_next = in_range && ((lrdata & mask) != '0);
                default:       res_flag_next = 1'b0;
            endcase
        end

        if (cmd.grow_wr)
        begin
            fwe = 1'b1;
            fwaddr = {nchunks_reg[CHUNK_W-1:0], ctr_reg[SLOT_W-1:0]};
            fwdata = ctr_reg[SLOT_W-1:0];
            ctr_next = ctr_reg + ADDR_W'(1);
            if (sts.grow_last)
            begin
                fd_next[nchunks_reg[CHUNK_W-1:0]] = DEPTH_W'(CHUNK_SLOTS);
                mk_en = 1'b1; mk_chunk = nchunks_reg[CHUNK_W-1:0];
                nchunks_next = nchunks_reg + NCH_W'(1);
            end
        end

        if (cmd.sw_eval)
        begin
            res_count_next = res_count_reg + CNT_W'(popcount(sel));
            vwaddr = row_reg;
            lwaddr = row_reg;
            case (req_reg) inside
                REQ_LOCK_ALL:   begin lwe = 1'b1; lwdata = lrdata | sel; end
                REQ_UNLOCK_ALL: begin lwe = 1'b1; lwdata = '0; end
                default:
                begin
                    vwe = 1'b1; vwdata = vrdata & ~sel;
                    pend_next = sel;
                end
            endcase
        end

        if (cmd.sw_push)
        begin
            push_en = 1'b1;
            push_chunk = row_reg[ROW_W-1:WORD_W];
            push_slot = {row_reg[WORD_W-1:0], low_idx};
            pend_next = pend_reg & (pend_reg - WORD_BITS'(1));
        end
        if (cmd.sw_next)
        begin
            row_next = row_reg + ROW_W'(1);
        end
        if (cmd.sw_end && (req_reg == REQ_DESTROY_ALL))
        begin
            live_next = live_reg - res_count_reg;
        end

        // free-slot push and usable-stack push
        if (push_en)
        begin
            if (fd_reg[push_chunk] < DEPTH_W'(CHUNK_SLOTS))
            begin
                fwe = 1'b1;
                fwaddr = {push_chunk, fd_reg[push_chunk][SLOT_W-1:0]};
                fwdata = push_slot;
                fd_next[push_chunk] = fd_reg[push_chunk] + DEPTH_W'(1);
            end
            mk_en = 1'b1; mk_chunk = push_chunk;
        end
        if (mk_en && !usable_reg[mk_chunk] && (udepth_reg < NCH_W'(MAX_CHUNKS)))
        begin
            ustack_next[udepth_reg[CHUNK_W-1:0]] = mk_chunk;
            usable_next[mk_chunk] = 1'b1;
            udepth_next = udepth_next + NCH_W'(1);
        end

        // output register
        if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            mvalid_next = 1'b1;
            mdata_next = {3'b000, live_reg, res_count_reg, res_flag_reg, res_gen_reg,
                          res_slot_reg, res_chunk_reg, res_status_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            for (int i = 0; i < MAX_CHUNKS; i++)
            begin
                fd_reg[i] <= '0;
            end
            usable_reg  <= '0;
            udepth_reg  <= '0;
            nchunks_reg <= '0;
            live_reg    <= '0;
            ctr_reg     <= '0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            limit_reg   <= limit_next;
            fd_reg      <= fd_next;
            usable_reg  <= usable_next;
            udepth_reg  <= udepth_next;
            nchunks_reg <= nchunks_next;
            live_reg    <= live_next;
            ctr_reg     <= ctr_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        chunk_reg      <= chunk_next;
        slot_reg       <= slot_next;
        gin_reg        <= gin_next;
        ustack_reg     <= ustack_next;
        res_status_reg <= res_status_next;
        res_chunk_reg  <= res_chunk_next;
        res_slot_reg   <= res_slot_next;
        res_gen_reg    <= res_gen_next;
        res_flag_reg   <= res_flag_next;
        res_count_reg  <= res_count_next;
        row_reg        <= row_next;
        pend_reg       <= pend_next;
        mdata_reg      <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    gha_ram #(.WIDTH(GEN_BITS), .DEPTH(ENTRIES)) u_gen_ram (
        .clk(clk), .we(gwe), .waddr(gwaddr), .wdata(gwdata),
        .raddr(graddr), .rdata(grdata)
    );

    gha_ram #(.WIDTH(WORD_BITS), .DEPTH(ROWS)) u_valid_ram (
        .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
        .raddr(vlraddr), .rdata(vrdata)
    );

    gha_ram #(.WIDTH(WORD_BITS), .DEPTH(ROWS)) u_lock_ram (
        .clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata),
        .raddr(vlraddr), .rdata(lrdata)
    );

    gha_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_free_ram (
        .clk(clk), .we(fwe), .waddr(fwaddr), .wdata(fwdata),
        .raddr(fraddr), .rdata(frdata)
    );

`ifndef SYNTHESIS
    a_udepth_le_chunks: assert property (@(posedge clk) disable iff (!rst_n)
        udepth_reg <= nchunks_reg)
        else $error("usable stack deeper than grown chunks");
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= {nchunks_reg, {SLOT_W{1'b0}}})
        else $error("live count exceeds grown capacity");
    a_top_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        (udepth_reg != '0) |-> (fd_reg[top_chunk] != '0))
        else $error("top usable chunk has no free slot");
`endif

endmodule

[hdl/gha_ctrl.sv]
// gha_ctrl: sequencing state machine of the handle allocator
// uses gha_pkg; drives gha_datapath through cmd_t and reads sts_t
module gha_ctrl
    import gha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   sw_more;

    assign sw_more = !sts.last_row;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:     if (s_tvalid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (sts.req) inside
                    REQ_CREATE, REQ_RESTORE:
                        state_next = sts.take_ok ? S_FETCH : S_DONE;
                    REQ_DESTROY, REQ_LOCK, REQ_UNLOCK, REQ_IS_ALIVE, REQ_IS_LOCKED:
                        state_next = S_MODIFY;
                    REQ_GROW:
                        state_next = sts.grow_ok ? S_GROW : S_DONE;
                    REQ_DESTROY_ALL, REQ_LOCK_ALL, REQ_UNLOCK_ALL:
                        state_next = sts.have_chunks ? S_SW_ADDR : S_DONE;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_FETCH:    state_next = S_MODIFY;
            S_MODIFY:   state_next = S_DONE;
            S_GROW:     if (sts.grow_last) state_next = S_DONE;
            S_SW_ADDR:  state_next = S_SW_DATA;
            S_SW_DATA:
            begin
                if ((sts.req == REQ_DESTROY_ALL) && sts.sel_nz)
                begin
                    state_next = S_SW_PUSH;
                end
                else
                begin
                    state_next = sw_more ? S_SW_ADDR : S_SW_END;
                end
            end
            S_SW_PUSH:
            begin
                if (!sts.rest_nz)
                begin
                    state_next = sw_more ? S_SW_ADDR : S_SW_END;
                end
            end
            S_SW_END:   state_next = S_DONE;
            S_DONE:     if (sts.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_CLEAR:    cmd.clr_wr = 1'b1;
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DISPATCH:
            begin
                case (sts.req) inside
                    REQ_CREATE, REQ_RESTORE:
                    begin
                        cmd.pop_rd = sts.take_ok;
                        cmd.finish_direct = !sts.take_ok;
                    end
                    REQ_DESTROY, REQ_LOCK, REQ_UNLOCK, REQ_IS_ALIVE, REQ_IS_LOCKED:
                        cmd.slot_rd_req = 1'b1;
                    REQ_GROW:
                        cmd.finish_direct = !sts.grow_ok;
                    REQ_DESTROY_ALL, REQ_LOCK_ALL, REQ_UNLOCK_ALL:
                        cmd.finish_direct = !sts.have_chunks;
                    default:
                        cmd.finish_direct = 1'b1;
                endcase
            end
            S_FETCH:    cmd.slot_rd_top = 1'b1;
            S_MODIFY:   cmd.modify = 1'b1;
            S_GROW:     cmd.grow_wr = 1'b1;
            S_SW_ADDR:  cmd.sw_rd = 1'b1;
            S_SW_DATA:
            begin
                cmd.sw_eval = 1'b1;
                cmd.sw_next = !((sts.req == REQ_DESTROY_ALL) && sts.sel_nz) && sw_more;
            end
            S_SW_PUSH:
            begin
                cmd.sw_push = 1'b1;
                cmd.sw_next = !sts.rest_nz && sw_more;
            end
            S_SW_END:   cmd.sw_end = 1'b1;
            S_DONE:     cmd.load_out = sts.out_free;
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/generational_handle_allocator_top.sv]
// generational_handle_allocator_top: top level of the handle allocator
// uses gha_pkg, gha_ctrl and gha_datapath (which holds the gha_ram memories)
//
// usage:
//  - s_tvalid/s_tready/s_tdata carry one request beat; m_tvalid/m_tready/m_tdata
//    carry exactly one result beat per request, in request order
//  - cfg_valid/cfg_ready/cfg_data write chunk_limit (reset 8); always ready,
//    write only while the block is idle
//  - after reset the block clears generation, valid and lock memories with
//    s_tready low; config writes are taken meanwhile
//  - one request at a time: create/restore run dispatch, fetch, modify, done;
//    other single-handle requests dispatch, modify, done; live_count and
//    refused ones dispatch, done; grow writes the new chunk's free stack one
//    entry a cycle; sweeps read one 32-slot bitmap row at a time over all grown
//    chunks, and destroy_all adds one push step per freed slot
//  - the result sits in an output register; a new request is taken while it
//    waits, and processing stalls at completion until the result is taken
module generational_handle_allocator_top
    import gha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // req_type[3:0], chunk_index[6:4], slot_index[16:7], handle_generation[32:17]
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // status[2:0], out_chunk[5:3], out_slot[15:6], out_generation[31:16],
    // flag[32], count[46:33], total_live[60:47]
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LIM_W-1:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    gha_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts(sts),
        .cmd(cmd)
    );

    gha_datapath u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .sts(sts),
        .s_tdata(s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_data(cfg_data),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

endmodule
